@@ sv/sfc_pkg.sv @@
// sfc_pkg: shared types and constants of the serial frame checker.
// Used by sfc_parser, sfc_counters, serial_frame_checker and sfc_checker.
`default_nettype none

package sfc_pkg;

    // frame format
    localparam int unsigned HDR_BYTES = 16;
    localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);
    localparam logic [31:0] HDR_MAGIC = 32'hABCD1234;
    localparam logic [31:0] HASH_BASIS = 32'h811C9DC5;
    localparam logic [31:0] HASH_PRIME = 32'h01000193;
    localparam logic [31:0] SAT32 = 32'hFFFFFFFF;

    // configuration register
    localparam int unsigned CFG_W = 13;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SYNC = 2'd1,
        ST_LEN  = 2'd2,
        ST_CSUM = 2'd3
    } t_status;

    // header window, byte 0 is the first byte received
    typedef logic [HDR_BYTES-1:0][7:0] t_window;

    // one reported frame event
    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [31:0] seq;
        logic [31:0] len;
    } t_event;

    // statistics counters
    typedef struct packed {
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
        logic [31:0] sync_losses;
        logic [31:0] good_bytes;
    } t_counts;

endpackage

`default_nettype wire

@@ sv/sfc_parser.sv @@
// sfc_parser: header window, resync search, length check and FNV-1a payload hash.
// Depends on sfc_pkg.
`default_nettype none

module sfc_parser #(
    parameter int unsigned MAX_PAYLOAD_BYTES = 4096
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_adv,
    input  wire logic [7:0]                       i_byte,
    input  wire logic [$clog2(MAX_PAYLOAD_BYTES+1)-1:0] i_limit,
    output sfc_pkg::t_event                       o_event
);

    localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);

    typedef enum logic [1:0] {
        PH_COLLECT = 2'd0,
        PH_RESYNC  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    t_phase                         r_phase, n_phase;
    sfc_pkg::t_window               r_win, n_win;
    logic [sfc_pkg::HDR_IDX_W-1:0]  r_fill, n_fill;
    logic [LEN_W-1:0]               r_left, n_left;
    logic [31:0]                    r_hash, n_hash;
    logic [31:0]                    hash_step;
    logic [31:0]                    w_magic, w_seq, w_len, w_csum;
    logic                           judge, finish;
    sfc_pkg::t_event                ev;

    // FNV-1a step on the incoming byte
    assign hash_step = (r_hash ^ {24'd0, i_byte}) * sfc_pkg::HASH_PRIME;

    // next header window: slide while resyncing, fill while collecting
    always_comb begin
        n_win = r_win;
        case (r_phase)
            PH_PAYLOAD: begin
                n_win = r_win;
            end
            PH_RESYNC: begin
                n_win = {i_byte, r_win[sfc_pkg::HDR_BYTES-1:1]};
            end
            default: begin
                n_win[r_fill] = i_byte;
            end
        endcase
    end

    // little-endian words of the updated window
    assign w_magic = n_win[3:0];
    assign w_seq   = n_win[7:4];
    assign w_len   = n_win[11:8];
    assign w_csum  = n_win[15:12];

    // next state and event for one byte
    always_comb begin
        n_phase = r_phase;
        n_fill  = r_fill;
        n_left  = r_left;
        n_hash  = r_hash;
        judge   = 1'b0;
        finish  = 1'b0;
        ev      = '0;

        case (r_phase)
            PH_PAYLOAD: begin
                n_hash = hash_step;
                n_left = r_left - LEN_W'(1);
                if (r_left == LEN_W'(1)) begin
                    finish = 1'b1;
                end
            end
            PH_RESYNC: begin
                if (w_magic == sfc_pkg::HDR_MAGIC) begin
                    judge = 1'b1;
                end
            end
            default: begin
                n_phase        = PH_COLLECT;
                n_fill         = r_fill + 1'b1;
                if (r_fill == {sfc_pkg::HDR_IDX_W{1'b1}}) begin
                    n_fill = '0;
                    if (w_magic != sfc_pkg::HDR_MAGIC) begin
                        ev.valid  = 1'b1;
                        ev.status = sfc_pkg::ST_SYNC;
                        n_phase   = PH_RESYNC;
                    end else begin
                        judge = 1'b1;
                    end
                end
            end
        endcase

        // judge a header whose magic is in place
        if (judge) begin
            if (w_len > 32'(i_limit)) begin
                ev.valid  = 1'b1;
                ev.status = sfc_pkg::ST_LEN;
                n_phase   = PH_COLLECT;
                n_fill    = '0;
                n_left    = '0;
            end else begin
                n_hash = sfc_pkg::HASH_BASIS;
                if (w_len == 32'd0) begin
                    finish = 1'b1;
                end else begin
                    n_left  = LEN_W'(w_len);
                    n_phase = PH_PAYLOAD;
                end
            end
        end

        // close the frame and compare the checksum
        if (finish) begin
            ev.valid  = 1'b1;
            ev.status = (n_hash == w_csum) ? sfc_pkg::ST_OK : sfc_pkg::ST_CSUM;
            n_phase   = PH_COLLECT;
            n_fill    = '0;
            n_left    = '0;
        end

        ev.seq = w_seq;
        ev.len = w_len;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COLLECT;
            r_fill  <= '0;
            r_left  <= '0;
            r_hash  <= sfc_pkg::HASH_BASIS;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_left  <= n_left;
            r_hash  <= n_hash;
        end
    end

    // header window, fully written before it is read
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_win <= n_win;
        end
    end

    assign o_event = ev;

endmodule

`default_nettype wire

@@ sv/sfc_counters.sv @@
// sfc_counters: saturating good/bad/sync/byte statistics.
// Depends on sfc_pkg.
`default_nettype none

module sfc_counters (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sfc_pkg::t_event i_event,
    output sfc_pkg::t_counts     o_next
);

    sfc_pkg::t_counts r_cnt, n_cnt;
    logic             is_ok, is_sync, is_bad;
    logic [33:0]      byte_sum;

    assign is_ok   = i_event.valid && (i_event.status == sfc_pkg::ST_OK);
    assign is_sync = i_event.valid && (i_event.status == sfc_pkg::ST_SYNC);
    assign is_bad  = i_event.valid && (i_event.status != sfc_pkg::ST_OK);

    assign byte_sum = 34'(r_cnt.good_bytes) + 34'(i_event.len)
                    + 34'(sfc_pkg::HDR_BYTES);

    // saturating updates
    always_comb begin
        n_cnt = r_cnt;
        if (is_ok && r_cnt.good_frames != sfc_pkg::SAT32) begin
            n_cnt.good_frames = r_cnt.good_frames + 32'd1;
        end
        if (is_bad && r_cnt.bad_frames != sfc_pkg::SAT32) begin
            n_cnt.bad_frames = r_cnt.bad_frames + 32'd1;
        end
        if (is_sync && r_cnt.sync_losses != sfc_pkg::SAT32) begin
            n_cnt.sync_losses = r_cnt.sync_losses + 32'd1;
        end
        if (is_ok) begin
            n_cnt.good_bytes = (byte_sum > 34'(sfc_pkg::SAT32)) ? sfc_pkg::SAT32
                                                                 : byte_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_event.valid) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_next = n_cnt;

endmodule

`default_nettype wire

@@ sv/serial_frame_checker.sv @@
// serial_frame_checker: framed packet receiver with FNV-1a payload check.
// Path: an accepted byte is held in the input register, and its result in the result register.
// Throughput: one byte per cycle, as long as the result slot does not stall;
// a stalled result holds only a byte that would emit the next result.
// Reset: synchronous, active low; clears phase, counters, the limit (to 4096) and both valids.
// Depends on sfc_pkg, sfc_parser and sfc_counters.
`default_nettype none

module serial_frame_checker #(
    parameter int unsigned MAX_PAYLOAD_BYTES = 4096
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [sfc_pkg::CFG_W-1:0] i_max_payload_len,
    // received bytes
    input  wire logic                      i_rx_valid,
    output logic                           o_rx_ready,
    input  wire logic [7:0]                i_rx_byte,
    // frame events
    output logic                           o_evt_valid,
    input  wire logic                      i_evt_ready,
    output logic [1:0]                     o_event_status,
    output logic [31:0]                    o_frame_seq,
    output logic [31:0]                    o_frame_len,
    output logic [31:0]                    o_good_frames,
    output logic [31:0]                    o_bad_frames,
    output logic [31:0]                    o_sync_losses,
    output logic [31:0]                    o_good_bytes
);

    localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);

    logic [sfc_pkg::CFG_W-1:0] r_max_len;
    logic                      r_in_valid;
    logic [7:0]                r_in_byte;
    logic                      adv;
    logic [31:0]               cfg_ext, lim_ext;
    logic [LEN_W-1:0]          limit;
    sfc_pkg::t_event           ev, ev_q;
    sfc_pkg::t_counts          cnt_next;
    logic                      r_out_valid;
    sfc_pkg::t_status          r_status;
    logic [31:0]               r_seq, r_len;
    sfc_pkg::t_counts          r_cnt;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= sfc_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_max_len <= i_max_payload_len;
        end
    end

    // effective limit: smaller of register and build maximum
    assign cfg_ext = 32'(r_max_len);
    assign lim_ext = (cfg_ext > 32'(MAX_PAYLOAD_BYTES)) ? 32'(MAX_PAYLOAD_BYTES) : cfg_ext;
    assign limit   = LEN_W'(lim_ext);

    // advance the held beat unless it emits a result while the result slot is stuck
    assign adv        = r_in_valid && (!ev.valid || !r_out_valid || i_evt_ready);
    assign o_rx_ready = !r_in_valid || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sfc_parser #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_limit (limit),
        .o_event (ev)
    );

    // only count events of beats that actually advance
    always_comb begin
        ev_q       = ev;
        ev_q.valid = ev.valid && adv;
    end

    sfc_counters u_counters (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_event (ev_q),
        .o_next  (cnt_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ev_q.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_evt_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ev_q.valid) begin
            r_status <= ev.status;
            r_seq    <= ev.seq;
            r_len    <= ev.len;
            r_cnt    <= cnt_next;
        end
    end

    assign o_evt_valid    = r_out_valid;
    assign o_event_status = r_status;
    assign o_frame_seq    = r_seq;
    assign o_frame_len    = r_len;
    assign o_good_frames  = r_cnt.good_frames;
    assign o_bad_frames   = r_cnt.bad_frames;
    assign o_sync_losses  = r_cnt.sync_losses;
    assign o_good_bytes   = r_cnt.good_bytes;

endmodule

`default_nettype wire

@@ sv/sfc_checker.sv @@
// sfc_checker: port-level assertions for serial_frame_checker, bound to the top level.
// Depends on sfc_pkg.
`default_nettype none

module sfc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_evt_valid,
    input wire logic        i_evt_ready,
    input wire logic [1:0]  o_event_status,
    input wire logic [31:0] o_frame_seq,
    input wire logic [31:0] o_good_frames,
    input wire logic [31:0] o_bad_frames,
    input wire logic [31:0] o_sync_losses,
    input wire logic [31:0] o_good_bytes
);

    // reset empties the result slot
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_evt_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_valid && !i_evt_ready |=> o_evt_valid && $stable(o_frame_seq))
        else $error("stalled result changed");

    // every sync loss is also a bad frame
    a_bad_covers_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_valid |-> o_bad_frames >= o_sync_losses)
        else $error("bad frame count below sync loss count");

    // a good frame is counted in frames and bytes
    a_ok_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_valid && o_event_status == sfc_pkg::ST_OK
            |-> o_good_frames != 32'd0 && o_good_bytes >= 32'(sfc_pkg::HDR_BYTES))
        else $error("good frame not counted");

    // a sync loss is counted
    a_sync_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_valid && o_event_status == sfc_pkg::ST_SYNC
            |-> o_sync_losses != 32'd0 && o_bad_frames != 32'd0)
        else $error("sync loss not counted");

endmodule

bind serial_frame_checker sfc_checker u_sfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_evt_valid    (o_evt_valid),
    .i_evt_ready    (i_evt_ready),
    .o_event_status (o_event_status),
    .o_frame_seq    (o_frame_seq),
    .o_good_frames  (o_good_frames),
    .o_bad_frames   (o_bad_frames),
    .o_sync_losses  (o_sync_losses),
    .o_good_bytes   (o_good_bytes)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking testbench for serial_frame_checker.
// Drives headers and payloads with random idling, tracks every frame in a local
// copy of the framing rules and checks each event beat. Depends on sfc_pkg.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned PAYLOAD_CAP = 4096;

    typedef enum logic [1:0] {
        RX_HEADER,
        RX_RESYNC,
        RX_PAYLOAD
    } t_rx_phase;

    typedef enum logic [2:0] {
        FR_GOOD,
        FR_BAD_CSUM,
        FR_OVERSIZE,
        FR_BAD_MAGIC,
        FR_NOISE
    } t_frame_kind;

    typedef enum logic [1:0] {
        EV_ALWAYS,
        EV_COIN,
        EV_PERIODIC,
        EV_BURSTY
    } t_stall_mode;

    typedef struct packed {
        sfc_pkg::t_status status;
        logic [31:0]      seq;
        logic [31:0]      len;
        logic [31:0]      good;
        logic [31:0]      bad;
        logic [31:0]      sync;
        logic [31:0]      nbytes;
    } t_frame_event;

    // Tracks the receiver state byte by byte and holds the frame events still owed
    class frame_judge;
        logic [sfc_pkg::CFG_W-1:0] limit_reg;
        t_rx_phase                 phase;
        sfc_pkg::t_window          win;
        int unsigned               fill;
        logic [12:0]               left;
        logic [31:0]               hash;
        logic [31:0]               good_cnt;
        logic [31:0]               bad_cnt;
        logic [31:0]               sync_cnt;
        logic [31:0]               byte_cnt;
        t_frame_event              expected_events[$];
        int unsigned               errors;

        function new();
            limit_reg = sfc_pkg::CFG_RESET;
            phase = RX_HEADER;
            win = '0;
            fill = 0;
            left = '0;
            hash = sfc_pkg::HASH_BASIS;
            good_cnt = '0;
            bad_cnt = '0;
            sync_cnt = '0;
            byte_cnt = '0;
            errors = 0;
        endfunction

        function void set_limit(logic [sfc_pkg::CFG_W-1:0] v);
            limit_reg = v;
        endfunction

        function int unsigned pending();
            return expected_events.size();
        endfunction

        // little-endian 32-bit word k of the header window
        function logic [31:0] header_field(int unsigned k);
            return 32'(win[4*k +: 4]);
        endfunction

        function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? sfc_pkg::SAT32 : s[31:0];
        endfunction

        function void post_event(sfc_pkg::t_status st);
            t_frame_event ev;
            ev.status = st;
            ev.seq = header_field(1);
            ev.len = header_field(2);
            ev.good = good_cnt;
            ev.bad = bad_cnt;
            ev.sync = sync_cnt;
            ev.nbytes = byte_cnt;
            expected_events.push_back(ev);
        endfunction

        function void restart();
            phase = RX_HEADER;
            fill = 0;
            left = '0;
        endfunction

        // compare the payload hash with the header checksum and close the frame
        function void close_frame();
            if (hash == header_field(3)) begin
                good_cnt = sat_add(good_cnt, 32'd1);
                byte_cnt = sat_add(byte_cnt, sat_add(header_field(2), sfc_pkg::HDR_BYTES));
                restart();
                post_event(sfc_pkg::ST_OK);
            end else begin
                bad_cnt = sat_add(bad_cnt, 32'd1);
                restart();
                post_event(sfc_pkg::ST_CSUM);
            end
        endfunction

        // header with a good magic: check the length, then open the payload
        function void open_frame();
            logic [31:0] len;
            logic [31:0] cap;
            len = header_field(2);
            cap = (limit_reg > PAYLOAD_CAP) ? PAYLOAD_CAP : 32'(limit_reg);
            if (len > cap) begin
                bad_cnt = sat_add(bad_cnt, 32'd1);
                restart();
                post_event(sfc_pkg::ST_LEN);
                return;
            end
            hash = sfc_pkg::HASH_BASIS;
            if (len == 0) begin
                close_frame();
                return;
            end
            left = len[12:0];
            phase = RX_PAYLOAD;
        endfunction

        function void take_byte(logic [7:0] b);
            // payload: fold the byte into the hash
            if (phase == RX_PAYLOAD) begin
                hash = (hash ^ {24'h0, b}) * sfc_pkg::HASH_PRIME;
                if (left != 0) left--;
                if (left == 0) close_frame();
                return;
            end
            // lost sync: slide the window until the magic leads
            if (phase == RX_RESYNC) begin
                win = {b, win[sfc_pkg::HDR_BYTES-1:1]};
                if (header_field(0) == sfc_pkg::HDR_MAGIC) open_frame();
                return;
            end
            // gather a header
            phase = RX_HEADER;
            if (fill >= sfc_pkg::HDR_BYTES) fill = 0;
            win[fill] = b;
            fill++;
            if (fill < sfc_pkg::HDR_BYTES) return;
            fill = 0;
            if (header_field(0) != sfc_pkg::HDR_MAGIC) begin
                sync_cnt = sat_add(sync_cnt, 32'd1);
                bad_cnt = sat_add(bad_cnt, 32'd1);
                phase = RX_RESYNC;
                post_event(sfc_pkg::ST_SYNC);
            end else begin
                open_frame();
            end
        endfunction

        function void check_event(logic [1:0] st, logic [31:0] seq, logic [31:0] len,
                                  logic [31:0] good, logic [31:0] bad, logic [31:0] sync,
                                  logic [31:0] nbytes);
            t_frame_event ev;
            string diff;
            if (expected_events.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected event beat, status %0d seq %h", $realtime, st, seq);
                return;
            end
            ev = expected_events.pop_front();
            diff = "";
            if (st !== ev.status) diff = {diff, " status"};
            if (seq !== ev.seq) diff = {diff, " seq"};
            if (len !== ev.len) diff = {diff, " len"};
            if (good !== ev.good) diff = {diff, " good_frames"};
            if (bad !== ev.bad) diff = {diff, " bad_frames"};
            if (sync !== ev.sync) diff = {diff, " sync_losses"};
            if (nbytes !== ev.nbytes) diff = {diff, " good_bytes"};
            if (diff == "") return;
            errors++;
            if (errors <= 10) begin
                $display("%0t: event mismatch in%s", $realtime, diff);
                $display("  expected st=%0d seq=%h len=%h good=%0d bad=%0d sync=%0d bytes=%0d",
                         ev.status, ev.seq, ev.len, ev.good, ev.bad, ev.sync, ev.nbytes);
                $display("  actual   st=%0d seq=%h len=%h good=%0d bad=%0d sync=%0d bytes=%0d",
                         st, seq, len, good, bad, sync, nbytes);
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [sfc_pkg::CFG_W-1:0] i_max_payload_len = '0;
    logic                      i_rx_valid = 1'b0;
    logic                      o_rx_ready;
    logic [7:0]                i_rx_byte = '0;
    logic                      o_evt_valid;
    logic                      i_evt_ready = 1'b0;
    logic [1:0]                o_event_status;
    logic [31:0]               o_frame_seq;
    logic [31:0]               o_frame_len;
    logic [31:0]               o_good_frames;
    logic [31:0]               o_bad_frames;
    logic [31:0]               o_sync_losses;
    logic [31:0]               o_good_bytes;

    frame_judge  judge = new();
    logic [31:0] cur_limit = PAYLOAD_CAP;
    int unsigned burst_left = 0;

    serial_frame_checker #(
        .MAX_PAYLOAD_BYTES(PAYLOAD_CAP)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_max_payload_len(i_max_payload_len),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_evt_valid      (o_evt_valid),
        .i_evt_ready      (i_evt_ready),
        .o_event_status   (o_event_status),
        .o_frame_seq      (o_frame_seq),
        .o_frame_len      (o_frame_len),
        .o_good_frames    (o_good_frames),
        .o_bad_frames     (o_bad_frames),
        .o_sync_losses    (o_sync_losses),
        .o_good_bytes     (o_good_bytes)
    );

    always #4 i_clk = ~i_clk;

    // Event sink: switch at random between stall patterns
    t_stall_mode stall_mode = EV_ALWAYS;
    int unsigned mode_left = 0;
    int unsigned stall_left = 0;
    int unsigned tick = 0;

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        tick++;
        case (stall_mode)
            EV_ALWAYS: i_evt_ready <= 1'b1;
            EV_COIN: i_evt_ready <= 1'($urandom_range(0, 1));
            EV_PERIODIC: i_evt_ready <= (tick % 4 == 0);
            default: begin
                if (stall_left == 0) begin
                    stall_left = $urandom_range(1, 12);
                    i_evt_ready <= 1'b1;
                end else begin
                    stall_left--;
                    i_evt_ready <= 1'b0;
                end
            end
        endcase
    end

    // Check every event beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_evt_valid && i_evt_ready)
            judge.check_event(o_event_status, o_frame_seq, o_frame_len, o_good_frames,
                              o_bad_frames, o_sync_losses, o_good_bytes);
    end

    // Send one byte; open a new burst after a random gap when the old one runs out
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        judge.take_byte(b);
    endtask

    // Build a frame of the given kind and stream it out; noise sends len random bytes
    task automatic send_frame(input t_frame_kind kind, input logic [31:0] seq,
                              input logic [31:0] len);
        logic [31:0] csum;
        logic [31:0] magic;
        logic [31:0] hdr[4];
        logic [7:0]  body[$];
        if (kind == FR_NOISE) begin
            repeat (len) send_byte(8'($urandom));
            return;
        end
        csum = sfc_pkg::HASH_BASIS;
        magic = sfc_pkg::HDR_MAGIC;
        if (kind == FR_GOOD || kind == FR_BAD_CSUM) begin
            repeat (len) body.push_back(8'($urandom));
            foreach (body[i]) csum = (csum ^ {24'h0, body[i]}) * sfc_pkg::HASH_PRIME;
        end
        if (kind == FR_BAD_CSUM) csum ^= ($urandom | 32'h1);
        // bad magic: either one flipped bit or a random word
        if (kind == FR_BAD_MAGIC)
            magic = $urandom_range(0, 1)
                    ? sfc_pkg::HDR_MAGIC ^ (32'h1 << $urandom_range(0, 31))
                    : sfc_pkg::HDR_MAGIC ^ ($urandom | 32'h1);
        hdr = '{magic, seq, len, csum};
        foreach (hdr[w])
            for (int k = 0; k < 4; k++) send_byte(hdr[w][8*k +: 8]);
        foreach (body[i]) send_byte(body[i]);
    endtask

    // Random mix, mostly well-formed frames with short payloads
    task automatic run_random(input int unsigned count);
        int unsigned pick;
        logic [31:0] cap;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            cap = (cur_limit < 24) ? cur_limit : 32'd24;
            if ($urandom_range(0, 19) == 0) cap = (cur_limit < 200) ? cur_limit : 32'd200;
            if (pick < 60)
                send_frame(FR_GOOD, $urandom, $urandom_range(0, cap));
            else if (pick < 72)
                send_frame(FR_BAD_CSUM, $urandom, $urandom_range(0, cap));
            else if (pick < 82)
                send_frame(FR_OVERSIZE, $urandom, $urandom_range(0, 1) ?
                           cur_limit + $urandom_range(1, 8) : ($urandom | 32'h8000_0000));
            else if (pick < 92)
                send_frame(FR_BAD_MAGIC, $urandom, $urandom);
            else
                send_frame(FR_NOISE, '0, $urandom_range(1, 20));
        end
    endtask

    // Stop sending and let every owed event drain, plus the pipeline depth
    task automatic drain_events();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        burst_left = 0;
        while (judge.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [sfc_pkg::CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_max_payload_len <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        judge.set_limit(v);
        cur_limit = (v > PAYLOAD_CAP) ? PAYLOAD_CAP : 32'(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [sfc_pkg::CFG_W-1:0] plan[5];
        plan = '{13'd0, 13'h1FFF, 13'd20, 13'd4096, 13'($urandom_range(1, 63))};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at the reset limit
        send_frame(FR_GOOD, 32'hFFFF_FFFF, 0);
        send_frame(FR_GOOD, 32'h0, 1);
        send_frame(FR_BAD_CSUM, 32'h8000_0001, 3);
        send_frame(FR_BAD_CSUM, 32'h7FFF_FFFE, 0);
        send_frame(FR_OVERSIZE, 32'h1, PAYLOAD_CAP + 1);
        send_frame(FR_OVERSIZE, 32'h2, 32'hFFFF_FFFF);
        // lost sync, then resync straight into each kind of header
        send_frame(FR_BAD_MAGIC, 32'h3, 32'h0);
        send_frame(FR_GOOD, 32'h4, 0);
        send_frame(FR_BAD_MAGIC, 32'h5, 32'h7);
        send_frame(FR_OVERSIZE, 32'h6, 5000);
        send_frame(FR_BAD_MAGIC, 32'h7, 32'h2);
        send_frame(FR_BAD_CSUM, 32'h8, 2);
        send_frame(FR_BAD_MAGIC, 32'h9, 32'h4);
        send_frame(FR_GOOD, 32'hA, 5);
        // misaligned stream
        send_frame(FR_NOISE, '0, 5);
        send_frame(FR_GOOD, 32'hB, 4);
        run_random(4);

        // Limit settings: for limits up to 64, a frame at the limit passes and one over fails
        foreach (plan[p]) begin
            drain_events();
            write_limit(plan[p]);
            if (cur_limit <= 64) begin
                send_frame(FR_GOOD, $urandom, cur_limit);
                send_frame(FR_OVERSIZE, $urandom, cur_limit + 1);
            end
            run_random(3);
        end

        drain_events();
        if (judge.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ serial_frame_checker.f @@
sv/sfc_pkg.sv
sv/sfc_parser.sv
sv/sfc_counters.sv
sv/serial_frame_checker.sv
sv/sfc_checker.sv
tb/sv/tb_top.sv
